>>> rtl/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every edge, reset masks the check.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/rrwl_pkg.sv
`timescale 1ns / 1ps

package rrwl_pkg;

  // Request operations
  typedef enum logic [1:0] {
    OP_RD_LOCK   = 2'd0,
    OP_WR_LOCK   = 2'd1,
    OP_RD_UNLOCK = 2'd2,
    OP_WR_UNLOCK = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [2:0] {
    STAT_GRANTED  = 3'd0,
    STAT_WAIT     = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_NOT_HELD = 3'd3,
    STAT_OVERFLOW = 3'd4
  } status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC
  } state_t;

  localparam int DEPTH_W  = 16;
  localparam int ID_W     = 8;
  localparam int ENTRY_W  = 4;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

endpackage

>>> rtl/recursive_rw_lock_manager.sv
`timescale 1ns / 1ps

// Recursive reader/writer lock manager for one shared lock.
// Request channel (in_valid/in_ready): operation and requester_id, one beat
// per request. Response channel (out_valid/out_ready): status, write_depth
// and reader_entries, exactly one beat per request, in request order.
// A request is taken only while the sequencer is idle. It then walks the
// reader table one slot per cycle through the single comparator (owner
// match, first free slot, other live readers), then applies the update.
// The next request is taken only once that update is applied and the
// sequencer is back in idle.
// A finished response sits in the output register; the next request may be
// taken and scanned meanwhile, and its update waits in the apply step until
// the output register is free, so a stalled receiver loses nothing.
// Reset clears all valid bits, the write count and the response valid flag;
// no clearing pass is needed.
module recursive_rw_lock_manager #(
  parameter int READER_SLOTS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   operation,
  input  logic [rrwl_pkg::ID_W-1:0]    requester_id,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2:0]                   status,
  output logic [rrwl_pkg::DEPTH_W-1:0] write_depth,
  output logic [rrwl_pkg::ENTRY_W-1:0] reader_entries
);

  localparam int IW = $clog2(READER_SLOTS);
  localparam int CW = $clog2(READER_SLOTS + 1);
  localparam int DW = rrwl_pkg::DEPTH_W;
  localparam int NW = rrwl_pkg::ID_W;

  rrwl_pkg::state_t state, state_next;

  // Reader table: owner/depth in memory, valid bits in flops
  logic [NW-1:0]           mem_owner [READER_SLOTS];
  logic [DW-1:0]           mem_depth [READER_SLOTS];
  logic [READER_SLOTS-1:0] entry_valid;
  logic [CW-1:0]           n_valid;

  logic [DW-1:0] write_count;
  logic [NW-1:0] write_owner;

  // Captured request
  rrwl_pkg::op_t req_op;
  logic [NW-1:0] req_id;

  // Scan counter and registered read stage
  logic [CW-1:0] cnt;
  logic [IW-1:0] rd_slot;
  logic          rd_live;
  logic          rd_vbit;
  logic [NW-1:0] rd_owner;
  logic [DW-1:0] rd_depth;

  // Scan results
  logic          own_found;
  logic [IW-1:0] own_slot;
  logic [DW-1:0] own_depth;
  logic          free_found;
  logic [IW-1:0] free_slot;
  logic          others_rd;

  // Output register
  rrwl_pkg::status_t out_status;

  // Apply-step decisions
  rrwl_pkg::status_t   st_calc;
  logic                mem_we;
  logic [IW-1:0]       mem_waddr;
  logic [DW-1:0]       mem_wdepth;
  logic                vld_set, vld_clr;
  logic [DW-1:0]       wc_next;
  logic                wo_we;
  logic [CW-1:0]       n_valid_next;
  logic                commit;
  logic                other_writer;
  logic                cmp_match;

  assign in_ready       = (state == rrwl_pkg::ST_IDLE);
  assign status         = out_status;
  assign write_depth    = write_count;
  assign other_writer   = (write_count != '0) && (write_owner != req_id);
  assign cmp_match      = (rd_owner == req_id);
  assign commit         = (state == rrwl_pkg::ST_EXEC) && (!out_valid || out_ready);
  assign reader_entries = (32'(n_valid) > 32'd15) ? 4'd15 : 4'(n_valid);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rrwl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      rrwl_pkg::ST_IDLE: begin
        if (in_valid) state_next = rrwl_pkg::ST_SCAN;
      end
      rrwl_pkg::ST_SCAN: begin
        if (cnt == CW'(READER_SLOTS)) state_next = rrwl_pkg::ST_EXEC;
      end
      rrwl_pkg::ST_EXEC: begin
        if (commit) state_next = rrwl_pkg::ST_IDLE;
      end
      default: state_next = rrwl_pkg::ST_IDLE;
    endcase
  end

  // Apply step: decide status and table updates
  always_comb begin
    st_calc      = rrwl_pkg::STAT_GRANTED;
    mem_we       = 1'b0;
    mem_waddr    = own_slot;
    mem_wdepth   = own_depth;
    vld_set      = 1'b0;
    vld_clr      = 1'b0;
    wc_next      = write_count;
    wo_we        = 1'b0;
    n_valid_next = n_valid;
    unique case (req_op)
      rrwl_pkg::OP_RD_LOCK: begin
        if (other_writer) begin
          st_calc = rrwl_pkg::STAT_WAIT;
        end else if (own_found) begin
          if (own_depth == rrwl_pkg::DEPTH_MAX) begin
            st_calc = rrwl_pkg::STAT_OVERFLOW;
          end else begin
            mem_we     = 1'b1;
            mem_wdepth = own_depth + DW'(1);
          end
        end else if (!free_found) begin
          st_calc = rrwl_pkg::STAT_FULL;
        end else begin
          mem_we       = 1'b1;
          mem_waddr    = free_slot;
          mem_wdepth   = DW'(1);
          vld_set      = 1'b1;
          n_valid_next = n_valid + CW'(1);
        end
      end
      rrwl_pkg::OP_WR_LOCK: begin
        if (other_writer || others_rd) begin
          st_calc = rrwl_pkg::STAT_WAIT;
        end else if (write_count == rrwl_pkg::DEPTH_MAX) begin
          st_calc = rrwl_pkg::STAT_OVERFLOW;
        end else begin
          wc_next = write_count + DW'(1);
          wo_we   = 1'b1;
        end
      end
      rrwl_pkg::OP_RD_UNLOCK: begin
        if (!own_found) begin
          st_calc = rrwl_pkg::STAT_NOT_HELD;
        end else if (own_depth > DW'(1)) begin
          mem_we     = 1'b1;
          mem_wdepth = own_depth - DW'(1);
        end else begin
          mem_we       = 1'b1;
          mem_wdepth   = '0;
          vld_clr      = 1'b1;
          n_valid_next = n_valid - CW'(1);
        end
      end
      rrwl_pkg::OP_WR_UNLOCK: begin
        if ((write_count == '0) || (write_owner != req_id)) begin
          st_calc = rrwl_pkg::STAT_NOT_HELD;
        end else begin
          wc_next = write_count - DW'(1);
        end
      end
      default: st_calc = rrwl_pkg::STAT_NOT_HELD;
    endcase
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (commit && mem_we) begin
      mem_owner[mem_waddr] <= req_id;
      mem_depth[mem_waddr] <= mem_wdepth;
    end
    rd_owner <= mem_owner[cnt[IW-1:0]];
    rd_depth <= mem_depth[cnt[IW-1:0]];
    rd_vbit  <= entry_valid[cnt[IW-1:0]];
    rd_slot  <= cnt[IW-1:0];
  end

  // Request capture, scan results and write owner
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_op <= rrwl_pkg::op_t'(operation);
      req_id <= requester_id;
    end
    if (commit && wo_we) begin
      write_owner <= req_id;
    end
    if (state == rrwl_pkg::ST_SCAN && rd_live && rd_vbit && cmp_match && !own_found) begin
      own_slot  <= rd_slot;
      own_depth <= rd_depth;
    end
    if (state == rrwl_pkg::ST_SCAN && rd_live && !rd_vbit && !free_found) begin
      free_slot <= rd_slot;
    end
    if (commit) begin
      out_status <= st_calc;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      n_valid     <= '0;
      write_count <= '0;
      cnt         <= '0;
      rd_live     <= 1'b0;
      own_found   <= 1'b0;
      free_found  <= 1'b0;
      others_rd   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      // Start a scan
      if (in_valid && in_ready) begin
        cnt        <= '0;
        rd_live    <= 1'b0;
        own_found  <= 1'b0;
        free_found <= 1'b0;
        others_rd  <= 1'b0;
      end
      // One slot per cycle through the comparator
      if (state == rrwl_pkg::ST_SCAN) begin
        rd_live <= (cnt != CW'(READER_SLOTS));
        if (cnt != CW'(READER_SLOTS)) cnt <= cnt + CW'(1);
        if (rd_live) begin
          if (rd_vbit && cmp_match) own_found <= 1'b1;
          if (!rd_vbit) free_found <= 1'b1;
          if (rd_vbit && !cmp_match && (rd_depth != '0)) others_rd <= 1'b1;
        end
      end
      // Apply the update
      if (commit) begin
        write_count <= wc_next;
        n_valid     <= n_valid_next;
        if (vld_set) entry_valid[mem_waddr] <= 1'b1;
        if (vld_clr) entry_valid[mem_waddr] <= 1'b0;
      end
      // Response beat
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/rrwl_checker.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module rrwl_checker #(
  parameter int READER_SLOTS = 8
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [2:0]                   status,
  input logic [rrwl_pkg::DEPTH_W-1:0] write_depth,
  input logic [rrwl_pkg::ENTRY_W-1:0] reader_entries
);

  // A held response beat keeps its payload
  `ASSERT_CLK_RST(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(status) && $stable(reader_entries), "response changed while stalled")

  // Reset leaves no response pending
  `ASSERT_CLK(a_rst_empty, clk, rst |=> !out_valid, "response valid after reset")

  // A request beat makes the block busy for its scan
  `ASSERT_CLK_RST(a_busy, clk, rst, in_valid && in_ready |=> !in_ready, "request taken during scan")

  // Never more table entries than slots
  `ASSERT_CLK_RST(a_entries, clk, rst, out_valid |-> 32'(reader_entries) <= READER_SLOTS, "reader entry count beyond table size")

  // A refused lock leaves the write depth alone
  `ASSERT_CLK_RST(a_wait_depth, clk, rst, out_valid && out_ready ##1 out_valid && $changed(write_depth) |-> status == rrwl_pkg::STAT_GRANTED, "write depth moved on a refused request")

endmodule

bind recursive_rw_lock_manager rrwl_checker #(
  .READER_SLOTS(READER_SLOTS)
) u_rrwl_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .status(status),
  .write_depth(write_depth),
  .reader_entries(reader_entries)
);

>>> tb/recursive_rw_lock_manager_test.sv
`timescale 1ns / 1ps

module recursive_rw_lock_manager_test;

  localparam int SLOTS = 8;
  // Longest quiet spell is a send gap, the scan and a receive stall
  localparam int STALL_LIMIT = 4000;

  typedef logic [rrwl_pkg::ID_W-1:0]    id_t;
  typedef logic [rrwl_pkg::DEPTH_W-1:0] depth_t;
  typedef logic [rrwl_pkg::ENTRY_W-1:0] entries_t;

  typedef struct packed {
    rrwl_pkg::op_t op;
    id_t           id;
  } lock_req_t;

  typedef struct packed {
    rrwl_pkg::status_t st;
    depth_t            depth;
    entries_t          entries;
  } lock_reply_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] operation;
  id_t        requester_id;
  logic       out_valid;
  logic       out_ready;
  logic [2:0] status;
  depth_t     write_depth;
  entries_t   reader_entries;

  recursive_rw_lock_manager #(
    .READER_SLOTS(SLOTS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .requester_id(requester_id),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .write_depth(write_depth),
    .reader_entries(reader_entries)
  );

  // Shadow of the lock state
  bit     reader_held [SLOTS];
  id_t    reader_id [SLOTS];
  depth_t reader_depth [SLOTS];
  depth_t writer_depth = '0;
  id_t    writer_id = '0;

  lock_req_t   pend_q[$];
  lock_req_t   burst_q[$];
  lock_req_t   unlock_q[$];
  lock_reply_t lock_replies_due[$];
  lock_req_t   cur_req;

  bit calm = 1'b0;
  int requests_sent = 0;
  int replies_seen = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int send_gap = 0;
  int hold_gap = 0;
  int most_entries = 0;
  int status_tally [5];
  id_t pool [12];

  // Lock decision for one request; updates the shadow state
  function automatic lock_reply_t grant_decision(lock_req_t r);
    lock_reply_t res;
    int i;
    int own;
    int free_slot;
    int cnt;
    bit rival_reader;
    bit rival_writer;
    own = -1;
    free_slot = -1;
    rival_reader = 1'b0;
    cnt = 0;
    // descending walk so the lowest slot wins
    for (i = SLOTS - 1; i >= 0; i--) begin
      if (reader_held[i]) begin
        if (reader_id[i] == r.id) own = i;
        else rival_reader = 1'b1;
      end else begin
        free_slot = i;
      end
    end
    rival_writer = (writer_depth != '0) && (writer_id != r.id);
    res.st = rrwl_pkg::STAT_GRANTED;
    case (r.op)
      rrwl_pkg::OP_RD_LOCK: begin
        if (rival_writer) begin
          res.st = rrwl_pkg::STAT_WAIT;
        end else if (own >= 0) begin
          if (reader_depth[own] == rrwl_pkg::DEPTH_MAX) res.st = rrwl_pkg::STAT_OVERFLOW;
          else reader_depth[own] = reader_depth[own] + depth_t'(1);
        end else if (free_slot < 0) begin
          res.st = rrwl_pkg::STAT_FULL;
        end else begin
          reader_held[free_slot] = 1'b1;
          reader_id[free_slot] = r.id;
          reader_depth[free_slot] = depth_t'(1);
        end
      end
      rrwl_pkg::OP_WR_LOCK: begin
        if (rival_writer || rival_reader) begin
          res.st = rrwl_pkg::STAT_WAIT;
        end else if (writer_depth == rrwl_pkg::DEPTH_MAX) begin
          res.st = rrwl_pkg::STAT_OVERFLOW;
        end else begin
          writer_depth = writer_depth + depth_t'(1);
          writer_id = r.id;
        end
      end
      rrwl_pkg::OP_RD_UNLOCK: begin
        if (own < 0) begin
          res.st = rrwl_pkg::STAT_NOT_HELD;
        end else if (reader_depth[own] > depth_t'(1)) begin
          reader_depth[own] = reader_depth[own] - depth_t'(1);
        end else begin
          reader_depth[own] = '0;
          reader_held[own] = 1'b0;
        end
      end
      default: begin
        if (writer_depth == '0 || writer_id != r.id) res.st = rrwl_pkg::STAT_NOT_HELD;
        else writer_depth = writer_depth - depth_t'(1);
      end
    endcase
    for (i = 0; i < SLOTS; i++) begin
      if (reader_held[i]) cnt++;
    end
    res.depth = writer_depth;
    res.entries = (cnt > 15) ? entries_t'(15) : entries_t'(cnt);
    return res;
  endfunction

  task automatic add_req(input rrwl_pkg::op_t op, input id_t id);
    pend_q.push_back('{op: op, id: id});
  endtask

  // Shuffle the staged requests and queue them
  task automatic shuffle_flush();
    int i;
    int j;
    lock_req_t tmp;
    for (i = burst_q.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = burst_q[i];
      burst_q[i] = burst_q[j];
      burst_q[j] = tmp;
    end
    while (burst_q.size() != 0) pend_q.push_back(burst_q.pop_front());
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pend_q.size() != 0 || in_valid || lock_replies_due.size() != 0);
  endtask

  // Once everything has settled, release every hold the shadow knows of
  task automatic drop_all_holds();
    int i;
    wait_drained();
    for (i = 0; i < SLOTS; i++) begin
      if (reader_held[i])
        repeat (int'(reader_depth[i])) add_req(rrwl_pkg::OP_RD_UNLOCK, reader_id[i]);
    end
    repeat (int'(writer_depth)) add_req(rrwl_pkg::OP_WR_UNLOCK, writer_id);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        lock_replies_due.push_back(grant_decision(cur_req));
        requests_sent++;
      end
      if (in_valid && !in_ready) begin
        // beat not taken yet: hold it
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pend_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (!calm && (requests_sent / 64) % 4 != 3 && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 11);
        in_valid <= 1'b0;
      end else begin
        cur_req = pend_q.pop_front();
        operation <= cur_req.op;
        requester_id <= cur_req.id;
        in_valid <= 1'b1;
      end
    end
  end

  // Reply monitor and checker
  always @(posedge clk) begin
    lock_reply_t want;
    if (rst) begin
      out_ready <= 1'b0;
      hold_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (lock_replies_due.size() == 0) begin
          $error("reply with nothing outstanding: status %0d", status);
          mismatches++;
        end else begin
          want = lock_replies_due.pop_front();
          if (status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, status);
            mismatches++;
          end
          if (write_depth !== want.depth) begin
            $error("write_depth: expected %0d, got %0d", want.depth, write_depth);
            mismatches++;
          end
          if (reader_entries !== want.entries) begin
            $error("reader_entries: expected %0d, got %0d", want.entries, reader_entries);
            mismatches++;
          end
        end
        if (!$isunknown(status) && status <= rrwl_pkg::STAT_OVERFLOW) status_tally[status]++;
        if (!$isunknown(reader_entries) && int'(reader_entries) > most_entries)
          most_entries = int'(reader_entries);
        replies_seen++;
      end
      if (hold_gap > 0) begin
        hold_gap--;
        out_ready <= 1'b0;
      end else if (!calm && (replies_seen / 64) % 4 != 1 && $urandom_range(0, 5) == 0) begin
        hold_gap = $urandom_range(0, 11);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  // Stimulus
  initial begin
    int i;
    int k;
    int m;
    int n;
    int d;
    int queued_before;
    int next_clean;
    id_t who;
    id_t other;
    rst = 1'b1;
    in_valid = 1'b0;
    out_ready = 1'b0;
    operation = '0;
    requester_id = '0;
    for (i = 0; i < SLOTS; i++) begin
      reader_held[i] = 1'b0;
      reader_id[i] = '0;
      reader_depth[i] = '0;
    end
    for (i = 0; i < 5; i++) status_tally[i] = 0;

    // Directed: unlocks on an empty lock, upgrade, read under own write,
    // rivals waiting, table full and recursion while full
    add_req(rrwl_pkg::OP_RD_UNLOCK, 8'h00);
    add_req(rrwl_pkg::OP_WR_UNLOCK, 8'h00);
    add_req(rrwl_pkg::OP_RD_LOCK, 8'h00);
    add_req(rrwl_pkg::OP_WR_LOCK, 8'h00);
    add_req(rrwl_pkg::OP_RD_LOCK, 8'h00);
    add_req(rrwl_pkg::OP_RD_LOCK, 8'hFF);
    add_req(rrwl_pkg::OP_WR_LOCK, 8'hFF);
    add_req(rrwl_pkg::OP_WR_UNLOCK, 8'hFF);
    add_req(rrwl_pkg::OP_WR_UNLOCK, 8'h00);
    add_req(rrwl_pkg::OP_RD_LOCK, 8'hFF);
    add_req(rrwl_pkg::OP_WR_LOCK, 8'h00);
    add_req(rrwl_pkg::OP_RD_UNLOCK, 8'h00);
    add_req(rrwl_pkg::OP_RD_UNLOCK, 8'h00);
    add_req(rrwl_pkg::OP_RD_UNLOCK, 8'h00);
    for (i = 1; i < SLOTS; i++) add_req(rrwl_pkg::OP_RD_LOCK, i[rrwl_pkg::ID_W-1:0]);
    add_req(rrwl_pkg::OP_RD_LOCK, 8'h80);
    add_req(rrwl_pkg::OP_RD_LOCK, 8'h03);
    add_req(rrwl_pkg::OP_RD_UNLOCK, 8'hFF);
    add_req(rrwl_pkg::OP_RD_LOCK, 8'h80);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    drop_all_holds();

    // Random: lock sessions with random content, plus some noise
    for (i = 0; i < 12; i++) pool[i] = id_t'($urandom_range(0, 255));
    queued_before = requests_sent + pend_q.size();
    next_clean = 300;
    while (requests_sent + pend_q.size() - queued_before < 1350) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // crowd of readers, sometimes more than the table holds
          m = $urandom_range(1, 10);
          for (k = 0; k < m; k++) begin
            who = pool[$urandom_range(0, 11)];
            n = $urandom_range(1, 3);
            repeat (n) begin
              burst_q.push_back('{op: rrwl_pkg::OP_RD_LOCK, id: who});
              unlock_q.push_back('{op: rrwl_pkg::OP_RD_UNLOCK, id: who});
            end
          end
          shuffle_flush();
          if ($urandom_range(0, 1) == 0) begin
            who = pool[$urandom_range(0, 11)];
            add_req(rrwl_pkg::OP_WR_LOCK, who);
            unlock_q.push_back('{op: rrwl_pkg::OP_WR_UNLOCK, id: who});
          end
          while (unlock_q.size() != 0) burst_q.push_back(unlock_q.pop_front());
          shuffle_flush();
        end
        4, 5: begin
          // recursive writer, own reads under it, rivals knocking
          who = pool[$urandom_range(0, 11)];
          d = $urandom_range(1, 4);
          for (k = 0; k < d; k++) begin
            add_req(rrwl_pkg::OP_WR_LOCK, who);
            unlock_q.push_back('{op: rrwl_pkg::OP_WR_UNLOCK, id: who});
            if ($urandom_range(0, 1) == 0) begin
              add_req(rrwl_pkg::OP_RD_LOCK, who);
              unlock_q.push_back('{op: rrwl_pkg::OP_RD_UNLOCK, id: who});
            end
            if ($urandom_range(0, 1) == 0) begin
              other = pool[$urandom_range(0, 11)];
              add_req(rrwl_pkg::op_t'($urandom_range(0, 3)), other);
            end
          end
          while (unlock_q.size() != 0) burst_q.push_back(unlock_q.pop_front());
          shuffle_flush();
        end
        6, 7: begin
          // upgrade from own reads
          who = pool[$urandom_range(0, 11)];
          n = $urandom_range(1, 3);
          repeat (n) add_req(rrwl_pkg::OP_RD_LOCK, who);
          add_req(rrwl_pkg::OP_WR_LOCK, who);
          add_req(rrwl_pkg::OP_RD_LOCK, pool[$urandom_range(0, 11)]);
          add_req(rrwl_pkg::OP_WR_UNLOCK, who);
          repeat (n) add_req(rrwl_pkg::OP_RD_UNLOCK, who);
          if ($urandom_range(0, 2) == 0) add_req(rrwl_pkg::OP_RD_UNLOCK, who);
        end
        default: begin
          // noise over the whole id range
          m = $urandom_range(1, 4);
          for (k = 0; k < m; k++)
            add_req(rrwl_pkg::op_t'($urandom_range(0, 3)), id_t'($urandom_range(0, 255)));
        end
      endcase
      if (requests_sent + pend_q.size() - queued_before >= next_clean) begin
        drop_all_holds();
        next_clean += 300;
      end
    end

    // Last part, no idling: a short mixed burst over the id pool
    calm = 1'b1;
    drop_all_holds();
    for (k = 0; k < 24; k++)
      add_req(rrwl_pkg::op_t'($urandom_range(0, 3)), pool[$urandom_range(0, 11)]);
    drop_all_holds();

    wait_drained();
    repeat (3 * (SLOTS + 2)) @(posedge clk);
    $display("%0d requests checked: %0d granted, %0d must_wait, %0d table_full, %0d not_held",
             replies_seen, status_tally[rrwl_pkg::STAT_GRANTED],
             status_tally[rrwl_pkg::STAT_WAIT], status_tally[rrwl_pkg::STAT_FULL],
             status_tally[rrwl_pkg::STAT_NOT_HELD]);
    $display("lock corners, reader crowds, recursive writers and upgrades; %0d overflow, %0d %s",
             status_tally[rrwl_pkg::STAT_OVERFLOW], most_entries, "reader entries at most");
    if (mismatches == 0 && lock_replies_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
